/* rtl/ftwa_pkg.sv */
`timescale 1ns / 1ps

package ftwa_pkg;

  localparam int unsigned DIV_W  = 32;
  localparam int unsigned STEP_W = 6;

  localparam logic [17:0] CLAMP_US  = 18'd250000;
  localparam logic [31:0] CLAMP_HZ  = 32'd4;
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [31:0] NS_PER_S  = 32'd1000000000;
  localparam logic [31:0] HZ_RESET  = 32'd10000000;

  // Register index, taken from the word address.
  localparam logic REG_COUNTER_HZ = 1'b0;

  typedef struct packed {
    logic [DIV_W-1:0]  rem0;
    logic [DIV_W-1:0]  bits;
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

/* rtl/frame_time_window_averager_top.sv */
// Up to four divisions run one after another on one shared radix-2 divider that yields
// one quotient bit per cycle while busy; an end-frame beat uses none. The divider and
// output back-pressure set the item rate.
// A new beat is taken once the sequencer is back in idle, even while a result waits;
// none is taken while an earlier beat is still in the sequencer. Reset clears the control
// and window state and sets counter_hz to 10 MHz; the history memory is not cleared.
`timescale 1ns / 1ps

module frame_time_window_averager_top #(
  parameter int unsigned WINDOW = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [63:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [17:0] frame_time_us_o,
  output logic [31:0] frame_rate_hz_o,
  output logic [17:0] avg_frame_us_o,
  output logic [19:0] avg_rate_hz_o,
  output logic [31:0] frame_number_o
);
  import ftwa_pkg::*;

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FW = $clog2(WINDOW + 1);
  localparam int unsigned TW = $clog2(WINDOW * 250000 + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_FT   = 8'b0000_0100,
    S_RATE = 8'b0000_1000,
    S_WIN  = 8'b0001_0000,
    S_AVG  = 8'b0010_0000,
    S_AVGR = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e         state_q;
  logic [31:0]    hz_q;
  logic [63:0]    prev_q, d_q, prev_eff;
  logic [AW-1:0]  wp_q;
  logic [FW-1:0]  fill_q;
  logic [TW-1:0]  total_q;
  logic [31:0]    fcnt_q;
  logic [17:0]    ft_q, avg_q;
  logic [31:0]    rate_q;
  logic [19:0]    avgr_q;
  logic [49:0]    prod_q;
  logic           rate_ok_q, go_q, go_d;
  logic [17:0]    hist [WINDOW];
  logic [17:0]    rd_q;
  logic           out_valid_q;
  logic           accept, clamp, rate_ok, out_free, cfg_wr;
  logic [49:0]    tot_ext;
  div_req_t       div_req;
  logic           div_done;
  logic [31:0]    div_quot;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_COUNTER_HZ);
  assign prdata   = (paddr[2] == REG_COUNTER_HZ) ? hz_q : '0;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign prev_eff   = (prev_q == '0) ? timestamp_i : prev_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign clamp   = (d_q[63:30] != '0) || ({d_q[29:0], 2'b00} >= hz_q);
  assign rate_ok = (d_q[29:0] != '0) &&
                   ((d_q[29:0] >= 30'd5) || (34'(d_q[2:0]) * 34'(NS_PER_S) > 34'(hz_q)));
  assign tot_ext = 50'(total_q);

  assign go_d = ((state_q == S_MUL) && !clamp) ||
                ((state_q == S_FT) && div_done && rate_ok_q) ||
                (state_q == S_WIN) ||
                ((state_q == S_AVG) && div_done && (div_quot[17:0] != '0));

  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_FT: begin
        div_req.rem0    = prod_q[49:18];
        div_req.bits    = {prod_q[17:0], 14'd0};
        div_req.divisor = hz_q;
        div_req.steps   = STEP_W'(18);
      end
      S_RATE: begin
        div_req.rem0    = '0;
        div_req.bits    = hz_q;
        div_req.divisor = {2'b00, d_q[29:0]};
        div_req.steps   = STEP_W'(32);
      end
      S_AVG: begin
        div_req.rem0    = tot_ext[49:18];
        div_req.bits    = {tot_ext[17:0], 14'd0};
        div_req.divisor = 32'(fill_q);
        div_req.steps   = STEP_W'(18);
      end
      S_AVGR: begin
        div_req.rem0    = '0;
        div_req.bits    = {US_PER_S, 12'd0};
        div_req.divisor = {14'd0, avg_q};
        div_req.steps   = STEP_W'(20);
      end
      default: div_req = '0;
    endcase
  end

  ftwa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hz_q        <= HZ_RESET;
      prev_q      <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      fcnt_q      <= '0;
      ft_q        <= '0;
      rate_q      <= '0;
      avg_q       <= '0;
      avgr_q      <= '0;
      rate_ok_q   <= 1'b0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      go_q <= go_d;
      if (cfg_wr) begin
        hz_q <= pwdata;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (action_i) begin
              fcnt_q  <= fcnt_q + 32'd1;
              state_q <= S_DONE;
            end else begin
              prev_q  <= timestamp_i;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (clamp) begin
            ft_q    <= CLAMP_US;
            rate_q  <= CLAMP_HZ;
            state_q <= S_WIN;
          end else begin
            rate_ok_q <= rate_ok;
            state_q   <= S_FT;
          end
        end
        S_FT: begin
          if (div_done) begin
            ft_q <= div_quot[17:0];
            if (rate_ok_q) begin
              state_q <= S_RATE;
            end else begin
              rate_q  <= '0;
              state_q <= S_WIN;
            end
          end
        end
        S_RATE: begin
          if (div_done) begin
            rate_q  <= div_quot;
            state_q <= S_WIN;
          end
        end
        S_WIN: begin
          if (fill_q < FW'(WINDOW)) begin
            fill_q  <= fill_q + FW'(1);
            total_q <= total_q + TW'(ft_q);
          end else begin
            total_q <= total_q - TW'(rd_q) + TW'(ft_q);
          end
          wp_q    <= (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + AW'(1);
          state_q <= S_AVG;
        end
        S_AVG: begin
          if (div_done) begin
            avg_q <= div_quot[17:0];
            if (div_quot[17:0] != '0) begin
              state_q <= S_AVGR;
            end else begin
              avgr_q  <= '0;
              state_q <= S_DONE;
            end
          end
        end
        S_AVGR: begin
          if (div_done) begin
            avgr_q  <= div_quot[19:0];
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= hist[wp_q];
    if (state_q == S_WIN) begin
      hist[wp_q] <= ft_q;
    end
    if (accept) begin
      d_q <= timestamp_i - prev_eff;
    end
    if (state_q == S_MUL) begin
      prod_q <= 50'(d_q[29:0]) * 50'(US_PER_S);
    end
    if ((state_q == S_DONE) && out_free) begin
      frame_time_us_o <= ft_q;
      frame_rate_hz_o <= rate_q;
      avg_frame_us_o  <= avg_q;
      avg_rate_hz_o   <= avgr_q;
      frame_number_o  <= fcnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/ftwa_div.sv */
`timescale 1ns / 1ps

module ftwa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ftwa_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [31:0]       quot_o
);
  import ftwa_pkg::*;

  logic [DIV_W-1:0]  rem_q, bits_q, div_q, quot_q;
  logic [DIV_W-1:0]  rem_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    trial = {rem_q, bits_q[DIV_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= req_i.rem0;
      bits_q <= req_i.bits;
      div_q  <= req_i.divisor;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      bits_q <= {bits_q[DIV_W-2:0], 1'b0};
      quot_q <= {quot_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ftwa_pkg::*;

  localparam int unsigned WINDOW     = 64;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned MAX_SHOWN  = 10;

  localparam logic       ACT_BEGIN   = 1'b0;
  localparam logic       ACT_END     = 1'b1;
  localparam logic [2:0] ADDR_HZ     = {REG_COUNTER_HZ, 2'b00};
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  localparam int unsigned STALL_NONE   = 0;
  localparam int unsigned STALL_RANDOM = 1;
  localparam int unsigned STALL_PULSE  = 2;

  typedef struct packed {
    logic [17:0] frame_us;
    logic [31:0] rate_hz;
    logic [17:0] avg_us;
    logic [19:0] avg_hz;
    logic [31:0] frame_num;
  } frame_stats_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        action_i;
  logic [63:0] timestamp_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [17:0] frame_time_us_o;
  logic [31:0] frame_rate_hz_o;
  logic [17:0] avg_frame_us_o;
  logic [19:0] avg_rate_hz_o;
  logic [31:0] frame_number_o;

  always #2 clk_i = ~clk_i;

  frame_time_window_averager_top #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .timestamp_i    (timestamp_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_time_us_o(frame_time_us_o),
    .frame_rate_hz_o(frame_rate_hz_o),
    .avg_frame_us_o (avg_frame_us_o),
    .avg_rate_hz_o  (avg_rate_hz_o),
    .frame_number_o (frame_number_o)
  );

  // Shadow of the block state.
  logic [31:0] tick_hz;
  logic [63:0] last_stamp;
  logic [17:0] frame_history [WINDOW];
  logic [5:0]  hist_pos;
  logic [6:0]  hist_fill;
  logic [23:0] hist_total;
  logic [31:0] frames_done;
  logic [17:0] held_frame_us;
  logic [31:0] held_rate_hz;
  logic [17:0] held_avg_us;
  logic [19:0] held_avg_hz;

  frame_stats_t pending_stats[$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;
  int unsigned  burst_left;
  logic [63:0]  stim_stamp;
  int unsigned  stall_mode;
  int unsigned  stall_left;
  int unsigned  stall_tick;

  function automatic frame_stats_t update_frame_stats(logic act, logic [63:0] stamp);
    logic [63:0]  delta;
    logic [63:0]  hz64;
    frame_stats_t stats;
    if (act == ACT_BEGIN) begin
      hz64 = {32'd0, tick_hz};
      if (last_stamp == 64'd0) last_stamp = stamp;
      delta = stamp - last_stamp;
      last_stamp = stamp;
      if (delta[63:62] != 2'b00 || (delta << 2) >= hz64) begin
        held_frame_us = CLAMP_US;
        held_rate_hz  = CLAMP_HZ;
      end else begin
        held_frame_us = 18'((delta * 64'd1000000) / hz64);
        if (delta != 64'd0 && delta * 64'(NS_PER_S) > hz64) held_rate_hz = 32'(hz64 / delta);
        else held_rate_hz = 32'd0;
      end
      if (hist_fill < WINDOW) hist_fill = hist_fill + 7'd1;
      else hist_total = hist_total - 24'(frame_history[hist_pos]);
      frame_history[hist_pos] = held_frame_us;
      hist_total = hist_total + 24'(held_frame_us);
      hist_pos = hist_pos + 6'd1;
      held_avg_us = 18'(hist_total / hist_fill);
      held_avg_hz = (held_avg_us != 18'd0) ? 20'(US_PER_S / held_avg_us) : 20'd0;
    end else begin
      frames_done = frames_done + 32'd1;
    end
    stats.frame_us  = held_frame_us;
    stats.rate_hz   = held_rate_hz;
    stats.avg_us    = held_avg_us;
    stats.avg_hz    = held_avg_hz;
    stats.frame_num = frames_done;
    return stats;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < MAX_SHOWN) $display("%s", what);
    mismatches++;
  endtask

  // Entered and left at a falling edge.
  task automatic apb_transfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_counter_hz(input logic [31:0] hz);
    logic [31:0] readback;
    apb_transfer(1'b1, ADDR_HZ, hz, readback);
    tick_hz = hz;
    apb_transfer(1'b0, ADDR_HZ, 32'd0, readback);
    if (readback !== hz)
      note_mismatch($sformatf("counter_hz readback: expected %0d, got %0d", hz, readback));
  endtask

  // Entered and left at a falling edge; valid stays high for a back-to-back beat.
  task automatic send_beat(input logic act, input logic [63:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 150);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    action_i    <= act;
    timestamp_i <= stamp;
    if (act == ACT_BEGIN) stim_stamp = stamp;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_stats.insert(pending_stats.size(), update_frame_stats(act, stamp));
    @(negedge clk_i);
  endtask

  task automatic next_frame(input logic [63:0] delta);
    send_beat(ACT_BEGIN, stim_stamp + delta);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_first_frame_and_wrap();
    send_beat(ACT_END, 64'd0);
    send_beat(ACT_BEGIN, 64'd1000);
    next_frame(64'd0);
    next_frame(64'd1);
    next_frame(64'd166666);
    next_frame(64'd2499999);
    next_frame(64'd2500000);
    send_beat(ACT_BEGIN, stim_stamp - 64'd5);
    send_beat(ACT_BEGIN, 64'd0);
    send_beat(ACT_BEGIN, '1);
    send_beat(ACT_BEGIN, 64'd0);
    send_beat(ACT_BEGIN, 64'd12345);
    send_beat(ACT_END, '1);
    wait_idle();
  endtask

  task automatic test_counter_hz_extremes();
    logic [31:0] unused;
    set_counter_hz(32'hFFFF_FFFF);
    next_frame(64'd4);
    next_frame(64'd5);
    next_frame(64'd1073741823);
    next_frame(64'd1073741824);
    wait_idle();
    set_counter_hz(32'd1);
    next_frame(64'd0);
    next_frame(64'd1);
    wait_idle();
    set_counter_hz(32'd0);
    next_frame(64'd0);
    next_frame(64'd7);
    wait_idle();
    apb_transfer(1'b1, ADDR_UNUSED, 32'd12345, unused);
    next_frame(64'd1);
    wait_idle();
  endtask

  task automatic test_random_frames(input logic [31:0] hz, input int unsigned beats);
    logic [31:0] quarter;
    int unsigned pick;
    set_counter_hz(hz);
    stim_stamp = {$urandom, $urandom};
    repeat (beats) begin
      quarter = tick_hz >> 2;
      pick = $urandom_range(0, 99);
      if (pick < 12) send_beat(ACT_END, {$urandom, $urandom});
      else if (pick < 55) next_frame(64'($urandom_range(0, quarter)));
      else if (pick < 68) next_frame(64'(quarter) + 64'($urandom_range(0, 2)) - 64'd1);
      else if (pick < 75) next_frame(64'($urandom_range(0, 5)));
      else if (pick < 86) send_beat(ACT_BEGIN, {$urandom, $urandom});
      else if (pick < 93) send_beat(ACT_BEGIN, stim_stamp - 64'($urandom_range(1, 100000)));
      else send_beat(ACT_BEGIN, 64'd0);
    end
    wait_idle();
  endtask

  always @(posedge clk_i) begin : check_results
    frame_stats_t got;
    frame_stats_t want;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = '{frame_time_us_o, frame_rate_hz_o, avg_frame_us_o, avg_rate_hz_o, frame_number_o};
      if (pending_stats.size() == 0) begin
        note_mismatch("Result beat with no expectation pending.");
      end else begin
        want = pending_stats.pop_front();
        if (got.frame_us !== want.frame_us || got.rate_hz !== want.rate_hz ||
            got.avg_us !== want.avg_us || got.avg_hz !== want.avg_hz ||
            got.frame_num !== want.frame_num)
          note_mismatch($sformatf(
            "Result mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
            want.frame_us, want.rate_hz, want.avg_us, want.avg_hz, want.frame_num,
            got.frame_us, got.rate_hz, got.avg_us, got.avg_hz, got.frame_num));
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_PULSE);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        out_stall_i <= (stall_tick % 23) < 9;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_BEGIN;
    timestamp_i = '0;
    out_stall_i = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    stall_mode  = STALL_NONE;
    stall_left  = 0;
    stall_tick  = 0;
    stim_stamp  = '0;
    tick_hz     = HZ_RESET;
    last_stamp  = '0;
    hist_pos    = '0;
    hist_fill   = '0;
    hist_total  = '0;
    frames_done = '0;
    held_frame_us = '0;
    held_rate_hz  = '0;
    held_avg_us   = '0;
    held_avg_hz   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_first_frame_and_wrap();
    test_counter_hz_extremes();
    test_random_frames(HZ_RESET, 130);
    test_random_frames(32'hFFFF_FFFF, 130);
    test_random_frames(32'd1, 130);
    test_random_frames($urandom_range(2, 1000), 130);
    test_random_frames($urandom, 130);
    test_random_frames(32'd60, 130);

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ftwa_pkg.sv
rtl/ftwa_div.sv
rtl/frame_time_window_averager_top.sv
tb/sv/testbench.sv
